// ===== sv/isd_pkg.sv =====
// package for the ising metropolis denoise step block
// shared constants, controller state type and command/status structs; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package isd_pkg;

    localparam int MAX_ROWS  = 256;
    localparam int MAX_COLS  = 256;
    localparam int ROW_W     = $clog2(MAX_ROWS);
    localparam int COL_W     = $clog2(MAX_COLS);
    localparam int ADDR_W    = ROW_W + COL_W;
    localparam int DEPTH     = MAX_ROWS * MAX_COLS;
    localparam int LIMIT_W   = 9;
    localparam int WEIGHT_W  = 16;
    localparam int DRAW_W    = 24;
    localparam int SUM_W     = 5;
    localparam int PROD_W    = WEIGHT_W + SUM_W;
    localparam int DELTA_W   = DRAW_W + 1;
    localparam int CFG_IDX_W = 2;

    localparam logic [1:0] ACT_LOAD   = 2'd0;
    localparam logic [1:0] ACT_UPDATE = 2'd1;

    localparam logic [CFG_IDX_W-1:0] REG_BETA  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAMMA = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COLS  = 2'd3;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd256;

    // neighbor offset index: minus one, zero, plus one
    localparam logic [1:0] OFS_LO  = 2'd0;
    localparam logic [1:0] OFS_MID = 2'd1;
    localparam logic [1:0] OFS_HI  = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_OOB_DONE,
        ST_LOAD_DONE,
        ST_READ_ISSUE,
        ST_READ_DONE,
        ST_SCAN,
        ST_SCAN_DRAIN,
        ST_MULT,
        ST_UPD_DONE
    } isd_state_t;

    typedef struct packed {
        logic capture;
        logic scan_clr;
        logic scan_step;
        logic mul;
        logic rd_issue;
        logic fin_oob;
        logic fin_load;
        logic fin_read;
        logic fin_upd;
    } isd_cmd_t;

    typedef struct packed {
        logic in_range;
        logic is_load;
        logic is_update;
        logic scan_last;
        logic out_free;
    } isd_status_t;

endpackage

`default_nettype wire

// ===== sv/isd_ctrl.sv =====
// controller state machine for the ising metropolis denoise step block
// sequences load, read and update transactions; depends on isd_pkg
`timescale 1ns / 1ps
`default_nettype none

module isd_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  isd_pkg::isd_status_t stat,
    output isd_pkg::isd_cmd_t    cmd
);
    import isd_pkg::*;

    isd_state_t state_reg;
    isd_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                priority if (!stat.in_range)
                begin
                    state_next = ST_OOB_DONE;
                end
                else if (stat.is_load)
                begin
                    state_next = ST_LOAD_DONE;
                end
                else if (stat.is_update)
                begin
                    state_next = ST_SCAN;
                end
                else
                begin
                    state_next = ST_READ_ISSUE;
                end
            end
            ST_OOB_DONE, ST_LOAD_DONE, ST_READ_DONE, ST_UPD_DONE:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_READ_ISSUE:
            begin
                state_next = ST_READ_DONE;
            end
            ST_SCAN:
            begin
                if (stat.scan_last)
                begin
                    state_next = ST_SCAN_DRAIN;
                end
            end
            ST_SCAN_DRAIN:
            begin
                state_next = ST_MULT;
            end
            ST_MULT:
            begin
                state_next = ST_UPD_DONE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.capture = in_valid;
            end
            ST_DISPATCH:
            begin
                cmd.scan_clr = 1'b1;
            end
            ST_OOB_DONE:
            begin
                cmd.fin_oob = stat.out_free;
            end
            ST_LOAD_DONE:
            begin
                cmd.fin_load = stat.out_free;
            end
            ST_READ_ISSUE:
            begin
                cmd.rd_issue = 1'b1;
            end
            ST_READ_DONE:
            begin
                // keep the centre pixel on the read port while the result waits
                cmd.rd_issue = 1'b1;
                cmd.fin_read = stat.out_free;
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
            end
            ST_SCAN_DRAIN:
            begin
            end
            ST_MULT:
            begin
                cmd.mul = 1'b1;
            end
            ST_UPD_DONE:
            begin
                cmd.fin_upd = stat.out_free;
            end
            default:
            begin
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/isd_datapath.sv =====
// datapath for the ising metropolis denoise step block
// config registers, spin stores, neighbor scan, energy compare, result register; uses isd_pkg
`timescale 1ns / 1ps
`default_nettype none

module isd_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  isd_pkg::isd_cmd_t                   cmd,
    output isd_pkg::isd_status_t                stat,
    input  logic                                cfg_valid,
    input  logic [isd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [isd_pkg::WEIGHT_W-1:0]        cfg_data,
    input  logic [1:0]                          action,
    input  logic [isd_pkg::ROW_W-1:0]           row,
    input  logic [isd_pkg::COL_W-1:0]           col,
    input  logic                                spin_in,
    input  logic signed [isd_pkg::DRAW_W-1:0]   log_draw,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                spin_out,
    output logic                                flipped,
    output logic signed [isd_pkg::SUM_W-1:0]    neighbour_sum,
    output logic                                status
);
    import isd_pkg::*;

    logic signed [WEIGHT_W-1:0] beta_reg;
    logic signed [WEIGHT_W-1:0] gamma_reg;
    logic [LIMIT_W-1:0]         rows_reg;
    logic [LIMIT_W-1:0]         cols_reg;

    logic [1:0]                 action_reg;
    logic [ROW_W-1:0]           row_reg;
    logic [COL_W-1:0]           col_reg;
    logic                       spin_reg;
    logic signed [DRAW_W-1:0]   draw_reg;

    logic                       cur_mem [DEPTH];
    logic                       orig_mem [DEPTH];
    logic                       cur_rdata_reg;
    logic                       orig_rdata_reg;

    logic [1:0]                 dr_reg;
    logic [1:0]                 dc_reg;
    logic                       pend_reg;
    logic                       pend_inb_reg;
    logic                       pend_centre_reg;
    logic signed [SUM_W-1:0]    sum_reg;
    logic                       cur_c_reg;
    logic                       orig_c_reg;
    logic signed [PROD_W-1:0]   term2h_reg;

    logic                       out_valid_reg;
    logic                       spin_out_reg;
    logic                       flipped_reg;
    logic signed [SUM_W-1:0]    nsum_out_reg;
    logic                       status_out_reg;

    logic [LIMIT_W-1:0]         row_ext;
    logic [LIMIT_W-1:0]         col_ext;
    logic [LIMIT_W-1:0]         nb_row;
    logic [LIMIT_W-1:0]         nb_col;
    logic                       row_ok;
    logic                       col_ok;
    logic [ADDR_W-1:0]          centre_addr;
    logic [ADDR_W-1:0]          nb_addr;
    logic [ADDR_W-1:0]          cur_raddr;
    logic                       cur_we;
    logic                       cur_wdata;
    logic signed [PROD_W-1:0]   prod;
    logic signed [WEIGHT_W:0]   g_ext;
    logic signed [WEIGHT_W:0]   term1h;
    logic signed [DELTA_W-1:0]  half_delta;
    logic signed [DELTA_W-1:0]  delta;
    logic signed [DELTA_W-1:0]  draw_ext;
    logic                       flip;
    logic                       out_free;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beta_reg  <= '0;
            gamma_reg <= '0;
            rows_reg  <= LIMIT_RESET;
            cols_reg  <= LIMIT_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_BETA:  beta_reg  <= cfg_data;
                REG_GAMMA: gamma_reg <= cfg_data;
                REG_ROWS:  rows_reg  <= cfg_data[LIMIT_W-1:0];
                REG_COLS:  cols_reg  <= cfg_data[LIMIT_W-1:0];
                default:   beta_reg  <= beta_reg;
            endcase
        end
    end

    // captured item
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            action_reg <= action;
            row_reg    <= row;
            col_reg    <= col;
            spin_reg   <= spin_in;
            draw_reg   <= log_draw;
        end
    end

    assign row_ext     = LIMIT_W'(row_reg);
    assign col_ext     = LIMIT_W'(col_reg);
    assign centre_addr = {row_reg, col_reg};
    assign nb_row      = row_ext + LIMIT_W'(dr_reg) - LIMIT_W'(1);
    assign nb_col      = col_ext + LIMIT_W'(dc_reg) - LIMIT_W'(1);
    assign nb_addr     = {nb_row[ROW_W-1:0], nb_col[COL_W-1:0]};

    always_comb
    begin
        unique case (dr_reg)
            OFS_LO:  row_ok = (row_reg != '0);
            OFS_MID: row_ok = 1'b1;
            OFS_HI:  row_ok = (row_reg != '1) && ((row_ext + LIMIT_W'(1)) < rows_reg);
            default: row_ok = 1'b0;
        endcase
        unique case (dc_reg)
            OFS_LO:  col_ok = (col_reg != '0);
            OFS_MID: col_ok = 1'b1;
            OFS_HI:  col_ok = (col_reg != '1) && ((col_ext + LIMIT_W'(1)) < cols_reg);
            default: col_ok = 1'b0;
        endcase
    end

    // spin stores
    assign cur_raddr = cmd.rd_issue ? centre_addr : nb_addr;
    assign cur_we    = cmd.fin_load || (cmd.fin_upd && flip);
    assign cur_wdata = cmd.fin_load ? spin_reg : !cur_c_reg;

    always_ff @(posedge clk)
    begin
        if (cur_we)
        begin
            cur_mem[centre_addr] <= cur_wdata;
        end
        cur_rdata_reg <= cur_mem[cur_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fin_load)
        begin
            orig_mem[centre_addr] <= spin_reg;
        end
        orig_rdata_reg <= orig_mem[centre_addr];
    end

    // neighbor scan
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dr_reg          <= OFS_LO;
            dc_reg          <= OFS_LO;
            pend_reg        <= 1'b0;
            pend_inb_reg    <= 1'b0;
            pend_centre_reg <= 1'b0;
            sum_reg         <= '0;
        end
        else
        begin
            pend_reg        <= cmd.scan_step;
            pend_inb_reg    <= row_ok && col_ok;
            pend_centre_reg <= (dr_reg == OFS_MID) && (dc_reg == OFS_MID);
            if (cmd.scan_clr)
            begin
                dr_reg  <= OFS_LO;
                dc_reg  <= OFS_LO;
                sum_reg <= '0;
            end
            else
            begin
                if (cmd.scan_step)
                begin
                    if (dc_reg == OFS_HI)
                    begin
                        dc_reg <= OFS_LO;
                        dr_reg <= dr_reg + 2'd1;
                    end
                    else
                    begin
                        dc_reg <= dc_reg + 2'd1;
                    end
                end
                if (pend_reg && pend_inb_reg && !pend_centre_reg)
                begin
                    sum_reg <= cur_rdata_reg ? sum_reg + SUM_W'(1) : sum_reg - SUM_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pend_reg && pend_centre_reg)
        begin
            cur_c_reg  <= cur_rdata_reg;
            orig_c_reg <= orig_rdata_reg;
        end
    end

    // energy change, half scale: -gamma*orig*cur - beta*cur*sum
    assign prod = beta_reg * sum_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            term2h_reg <= cur_c_reg ? -prod : prod;
        end
    end

    assign g_ext      = (WEIGHT_W+1)'(gamma_reg);
    assign term1h     = (orig_c_reg == cur_c_reg) ? -g_ext : g_ext;
    assign half_delta = DELTA_W'(term2h_reg) + DELTA_W'(term1h);
    assign delta      = half_delta <<< 1;
    assign draw_ext   = DELTA_W'(draw_reg);
    assign flip       = (draw_ext <= delta);

    // result register
    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.fin_oob || cmd.fin_load || cmd.fin_read || cmd.fin_upd)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        priority if (cmd.fin_oob)
        begin
            spin_out_reg   <= 1'b0;
            flipped_reg    <= 1'b0;
            nsum_out_reg   <= '0;
            status_out_reg <= 1'b1;
        end
        else if (cmd.fin_load)
        begin
            spin_out_reg   <= spin_reg;
            flipped_reg    <= 1'b0;
            nsum_out_reg   <= '0;
            status_out_reg <= 1'b0;
        end
        else if (cmd.fin_read)
        begin
            spin_out_reg   <= cur_rdata_reg;
            flipped_reg    <= 1'b0;
            nsum_out_reg   <= '0;
            status_out_reg <= 1'b0;
        end
        else if (cmd.fin_upd)
        begin
            spin_out_reg   <= cur_c_reg ^ flip;
            flipped_reg    <= flip;
            nsum_out_reg   <= sum_reg;
            status_out_reg <= 1'b0;
        end
        else
        begin
            spin_out_reg   <= spin_out_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign spin_out      = spin_out_reg;
    assign flipped       = flipped_reg;
    assign neighbour_sum = nsum_out_reg;
    assign status        = status_out_reg;

    assign stat.in_range  = (row_ext < rows_reg) && (col_ext < cols_reg);
    assign stat.is_load   = (action_reg == ACT_LOAD);
    assign stat.is_update = (action_reg == ACT_UPDATE);
    assign stat.scan_last = (dr_reg == OFS_HI) && (dc_reg == OFS_HI);
    assign stat.out_free  = out_free;

    a_sum_range: assert property (@(posedge clk) disable iff (!rst_n)
        (sum_reg >= -SUM_W'(8)) && (sum_reg <= SUM_W'(8)))
        else $error("neighbor sum out of range");

    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |->
            $past(cmd.fin_oob || cmd.fin_load || cmd.fin_read || cmd.fin_upd))
        else $error("result appeared without a finishing command");

    a_oob_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_out_reg) |->
            (!spin_out_reg && !flipped_reg && (nsum_out_reg == '0)))
        else $error("out-of-range result carries data");

    a_flip_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && flipped_reg) |-> !status_out_reg)
        else $error("flip reported with bad status");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> out_valid_reg)
        else $error("pending result dropped");

endmodule

`default_nettype wire

// ===== sv/ising_metropolis_denoise_step.sv =====
// top level of the ising metropolis denoise step block
// joins isd_ctrl and isd_datapath; depends on isd_pkg
`timescale 1ns / 1ps
`default_nettype none

// channel  direction  handshake             payload
// in       input      in_valid / in_stall   action, row, col, spin_in, log_draw
// out      output     out_valid / out_stall spin_out, flipped, neighbour_sum, status
// cfg      input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// one transaction at a time; a new one is taken while the last result waits
// update: scan, drain and multiply states; scan reads use the single read port
// load and out-of-range finish after dispatch; read passes an issue state first
// reset clears control and weights; spin stores hold nothing until loaded
// output stall holds the result register and delays the next finish

module ising_metropolis_denoise_step (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [1:0]                          action,
    input  logic [isd_pkg::ROW_W-1:0]           row,
    input  logic [isd_pkg::COL_W-1:0]           col,
    input  logic                                spin_in,
    input  logic signed [isd_pkg::DRAW_W-1:0]   log_draw,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                spin_out,
    output logic                                flipped,
    output logic signed [isd_pkg::SUM_W-1:0]    neighbour_sum,
    output logic                                status,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [isd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [isd_pkg::WEIGHT_W-1:0]        cfg_data
);
    import isd_pkg::*;

    isd_cmd_t    cmd;
    isd_status_t stat;

    assign cfg_ready = 1'b1;

    isd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    isd_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .cfg_valid     (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .action        (action),
        .row           (row),
        .col           (col),
        .spin_in       (spin_in),
        .log_draw      (log_draw),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .spin_out      (spin_out),
        .flipped       (flipped),
        .neighbour_sum (neighbour_sum),
        .status        (status)
    );

endmodule

`default_nettype wire

// ===== tb/isd_result_check.sv =====
`timescale 1ns / 1ps
// result checker for the ising metropolis denoise step block: watches the pixel, result
// and register channels, keeps its own copy of both spin images and the weights,
// predicts every result and compares it field by field; depends on isd_pkg

module isd_result_check
    import isd_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_stall,
    input  logic [1:0]                 action,
    input  logic [ROW_W-1:0]           row,
    input  logic [COL_W-1:0]           col,
    input  logic                       spin_in,
    input  logic signed [DRAW_W-1:0]   log_draw,
    input  logic                       out_valid,
    input  logic                       out_stall,
    input  logic                       spin_out,
    input  logic                       flipped,
    input  logic signed [SUM_W-1:0]    neighbour_sum,
    input  logic                       status,
    input  logic                       cfg_valid,
    input  logic                       cfg_ready,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [WEIGHT_W-1:0]        cfg_data,
    output int                         error_count,
    output int                         awaiting,
    output int                         checked_count,
    output int                         update_count,
    output int                         flip_count,
    output int                         off_image_count
);

    typedef struct packed {
        logic                    spin;
        logic                    flip;
        logic signed [SUM_W-1:0] nsum;
        logic                    off_image;
    } pixel_result_t;

    bit est_img [0:DEPTH-1];
    bit noisy_img [0:DEPTH-1];
    int beta_w = 0;
    int gamma_w = 0;
    logic [LIMIT_W-1:0] rows_cfg = LIMIT_RESET;
    logic [LIMIT_W-1:0] cols_cfg = LIMIT_RESET;
    pixel_result_t pending_results [$];
    int n_err = 0;
    int n_checked = 0;
    int n_upd = 0;
    int n_flip = 0;
    int n_off = 0;

    function automatic int clamp_limit(input logic [LIMIT_W-1:0] lim, input int max_lim);
        return (int'(lim) > max_lim) ? max_lim : int'(lim);
    endfunction

    function automatic pixel_result_t predict_pixel(
        input logic [1:0]               act,
        input logic [ROW_W-1:0]         r,
        input logic [COL_W-1:0]         c,
        input logic                     s,
        input logic signed [DRAW_W-1:0] draw
    );
        pixel_result_t res;
        int lim_r;
        int lim_c;
        int addr;
        int sum;
        int nr;
        int nc;
        int cur_v;
        int orig_v;
        int delta;
        res = '0;
        lim_r = clamp_limit(rows_cfg, MAX_ROWS);
        lim_c = clamp_limit(cols_cfg, MAX_COLS);
        if (int'(r) >= lim_r || int'(c) >= lim_c)
        begin
            res.off_image = 1'b1;
            return res;
        end
        addr = int'(r) * MAX_COLS + int'(c);
        if (act == ACT_LOAD)
        begin
            est_img[addr] = s;
            noisy_img[addr] = s;
            res.spin = s;
        end
        else if (act == ACT_UPDATE)
        begin
            sum = 0;
            for (int dr = -1; dr <= 1; dr++)
            begin
                for (int dc = -1; dc <= 1; dc++)
                begin
                    nr = int'(r) + dr;
                    nc = int'(c) + dc;
                    if ((dr != 0 || dc != 0) && nr >= 0 && nr < lim_r && nc >= 0 && nc < lim_c)
                        sum += est_img[nr * MAX_COLS + nc] ? 1 : -1;
                end
            end
            cur_v = est_img[addr] ? 1 : -1;
            orig_v = noisy_img[addr] ? 1 : -1;
            // energy change of a flip, same fixed point as the weights
            delta = -2 * gamma_w * orig_v * cur_v - 2 * beta_w * cur_v * sum;
            if (int'(draw) <= delta)
            begin
                est_img[addr] = !est_img[addr];
                res.flip = 1'b1;
            end
            res.spin = est_img[addr];
            res.nsum = sum[SUM_W-1:0];
        end
        else
            res.spin = est_img[addr];
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pixel_result_t want;
        if (!rst_n)
        begin
            beta_w = 0;
            gamma_w = 0;
            rows_cfg = LIMIT_RESET;
            cols_cfg = LIMIT_RESET;
            pending_results.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    n_err++;
                    $display("%0t: result with nothing expected: spin_out %0b status %0b",
                             $time, spin_out, status);
                end
                else
                begin
                    want = pending_results.pop_front();
                    n_checked++;
                    if (spin_out !== want.spin)
                    begin
                        n_err++;
                        $display("%0t: spin_out expected %0b actual %0b",
                                 $time, want.spin, spin_out);
                    end
                    if (flipped !== want.flip)
                    begin
                        n_err++;
                        $display("%0t: flipped expected %0b actual %0b",
                                 $time, want.flip, flipped);
                    end
                    if (neighbour_sum !== want.nsum)
                    begin
                        n_err++;
                        $display("%0t: neighbour_sum expected %0d actual %0d",
                                 $time, want.nsum, neighbour_sum);
                    end
                    if (status !== want.off_image)
                    begin
                        n_err++;
                        $display("%0t: status expected %0b actual %0b",
                                 $time, want.off_image, status);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_BETA:  beta_w = int'($signed(cfg_data));
                    REG_GAMMA: gamma_w = int'($signed(cfg_data));
                    REG_ROWS:  rows_cfg = cfg_data[LIMIT_W-1:0];
                    REG_COLS:  cols_cfg = cfg_data[LIMIT_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                want = predict_pixel(action, row, col, spin_in, log_draw);
                if (action == ACT_UPDATE && !want.off_image)
                    n_upd++;
                if (want.flip)
                    n_flip++;
                if (want.off_image)
                    n_off++;
                pending_results.push_back(want);
            end
        end
        error_count <= n_err;
        awaiting <= pending_results.size();
        checked_count <= n_checked;
        update_count <= n_upd;
        flip_count <= n_flip;
        off_image_count <= n_off;
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// top of the testbench for ising_metropolis_denoise_step: clock, reset, register
// settings and pixel transactions with random idling; depends on isd_pkg,
// isd_result_check and the block itself

module testbench;
    import isd_pkg::*;

    localparam logic [1:0] ACT_READ  = 2'd2;
    localparam logic [1:0] ACT_SPARE = 2'd3;
    localparam int ITEM_TARGET    = 450;
    localparam int PHASE_OPS      = 50;
    localparam int HOLD_CYCLES    = 80;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 30;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic [1:0]               action = ACT_LOAD;
    logic [ROW_W-1:0]         row = '0;
    logic [COL_W-1:0]         col = '0;
    logic                     spin_in = 1'b0;
    logic signed [DRAW_W-1:0] log_draw = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic                     spin_out;
    logic                     flipped;
    logic signed [SUM_W-1:0]  neighbour_sum;
    logic                     status;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index = REG_BETA;
    logic [WEIGHT_W-1:0]      cfg_data = '0;

    int error_count;
    int awaiting;
    int checked_count;
    int update_count;
    int flip_count;
    int off_image_count;

    bit loaded [0:DEPTH-1];
    int rows_lim = MAX_ROWS;
    int cols_lim = MAX_COLS;
    int items_sent = 0;
    int settings_used = 0;
    bit calm = 1'b0;
    int pressure_req = 0;
    int pressure_seen = 0;
    int hold_left = 0;
    int quiet_cycles = 0;

    ising_metropolis_denoise_step uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .action(action),
        .row(row),
        .col(col),
        .spin_in(spin_in),
        .log_draw(log_draw),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .spin_out(spin_out),
        .flipped(flipped),
        .neighbour_sum(neighbour_sum),
        .status(status),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    isd_result_check spin_check (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .action(action),
        .row(row),
        .col(col),
        .spin_in(spin_in),
        .log_draw(log_draw),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .spin_out(spin_out),
        .flipped(flipped),
        .neighbour_sum(neighbour_sum),
        .status(status),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .error_count(error_count),
        .awaiting(awaiting),
        .checked_count(checked_count),
        .update_count(update_count),
        .flip_count(flip_count),
        .off_image_count(off_image_count)
    );

    always #10 clk = ~clk;

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (pressure_seen != pressure_req)
        begin
            pressure_seen <= pressure_req;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= !calm && ($urandom_range(0, 99) < 35);
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic bit update_ok(input int r, input int c);
        bit ok;
        ok = 1'b1;
        for (int dr = -1; dr <= 1; dr++)
        begin
            for (int dc = -1; dc <= 1; dc++)
            begin
                if (r + dr >= 0 && r + dr < rows_lim && c + dc >= 0 && c + dc < cols_lim
                    && !loaded[(r + dr) * MAX_COLS + c + dc])
                    ok = 1'b0;
            end
        end
        return ok;
    endfunction

    function automatic logic [DRAW_W-1:0] any_draw();
        int v;
        case ($urandom_range(0, 5))
            0: v = $urandom;
            1: v = -int'($urandom_range(0, 600000));
            default: v = int'($urandom_range(0, 1200000)) - 600000;
        endcase
        return v[DRAW_W-1:0];
    endfunction

    function automatic int pick_weight();
        case ($urandom_range(0, 5))
            0: return -32768;
            1: return 32767;
            2: return 0;
            3: return int'($urandom_range(0, 65535)) - 32768;
            default: return int'($urandom_range(0, 8000)) - 4000;
        endcase
    endfunction

    function automatic int pick_limit();
        case ($urandom_range(0, 7))
            0: return 1;
            1: return 2;
            2: return MAX_ROWS;
            3: return $urandom_range(257, 511);
            default: return $urandom_range(3, 24);
        endcase
    endfunction

    task automatic pixel_op(input logic [1:0] act, input int r, input int c,
                            input logic s, input logic [DRAW_W-1:0] draw);
        if (!calm && $urandom_range(0, 99) < 35)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= act;
        row <= r[ROW_W-1:0];
        col <= c[COL_W-1:0];
        spin_in <= s;
        log_draw <= draw;
        do @(posedge clk); while (in_stall);
        if (act == ACT_LOAD && r < rows_lim && c < cols_lim)
            loaded[r * MAX_COLS + c] = 1'b1;
        items_sent++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (awaiting != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WEIGHT_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic apply_setting(input int beta, input int gamma, input int rows_v, input int cols_v);
        logic [WEIGHT_W-1:0] upper;
        drain_results();
        write_reg(REG_BETA, beta[WEIGHT_W-1:0]);
        write_reg(REG_GAMMA, gamma[WEIGHT_W-1:0]);
        // bits above the limit field are don't-care
        upper = $urandom;
        write_reg(REG_ROWS, {upper[WEIGHT_W-1:LIMIT_W], rows_v[LIMIT_W-1:0]});
        upper = $urandom;
        write_reg(REG_COLS, {upper[WEIGHT_W-1:LIMIT_W], cols_v[LIMIT_W-1:0]});
        cfg_valid <= 1'b0;
        rows_lim = (int'(rows_v[LIMIT_W-1:0]) > MAX_ROWS) ? MAX_ROWS : int'(rows_v[LIMIT_W-1:0]);
        cols_lim = (int'(cols_v[LIMIT_W-1:0]) > MAX_COLS) ? MAX_COLS : int'(cols_v[LIMIT_W-1:0]);
        settings_used++;
    endtask

    task automatic random_phase(input int ops);
        int span_r;
        int span_c;
        int base_r;
        int base_c;
        int r;
        int c;
        int pick;
        span_r = (rows_lim < 8) ? rows_lim : $urandom_range(3, 8);
        span_c = (cols_lim < 8) ? cols_lim : $urandom_range(3, 8);
        base_r = $urandom_range(0, rows_lim - span_r);
        base_c = $urandom_range(0, cols_lim - span_c);
        // load the working window so every update in it has defined neighbors
        for (r = base_r; r < base_r + span_r; r++)
        begin
            for (c = base_c; c < base_c + span_c; c++)
            begin
                if (!loaded[r * MAX_COLS + c] || $urandom_range(0, 3) == 0)
                    pixel_op(ACT_LOAD, r, c, 1'($urandom), any_draw());
            end
        end
        repeat (ops)
        begin
            r = base_r + $urandom_range(0, span_r - 1);
            c = base_c + $urandom_range(0, span_c - 1);
            pick = $urandom_range(0, 99);
            if (pick < 10 && (rows_lim < MAX_ROWS || cols_lim < MAX_COLS))
            begin
                if (cols_lim == MAX_COLS || (rows_lim < MAX_ROWS && $urandom_range(0, 1) == 1))
                begin
                    r = $urandom_range(rows_lim, MAX_ROWS - 1);
                    c = $urandom_range(0, MAX_COLS - 1);
                end
                else
                begin
                    r = $urandom_range(0, MAX_ROWS - 1);
                    c = $urandom_range(cols_lim, MAX_COLS - 1);
                end
                pixel_op(2'($urandom_range(0, 3)), r, c, 1'($urandom), any_draw());
            end
            else if (pick < 70 && update_ok(r, c))
                pixel_op(ACT_UPDATE, r, c, 1'($urandom), any_draw());
            else if (pick < 85)
                pixel_op(ACT_READ, r, c, 1'($urandom), any_draw());
            else if (pick < 90)
                pixel_op(ACT_SPARE, r, c, 1'($urandom), any_draw());
            else
                pixel_op(ACT_LOAD, r, c, 1'($urandom), any_draw());
        end
    endtask

    initial
    begin
        int phase;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // corners of the full image, extreme weights and draws
        apply_setting(32767, -32768, MAX_ROWS, MAX_COLS);
        pixel_op(ACT_LOAD, 0, 0, 1'b1, 24'h000000);
        pixel_op(ACT_LOAD, 0, 1, 1'b0, 24'hFFFFFF);
        pixel_op(ACT_LOAD, 1, 0, 1'b1, 24'h000000);
        pixel_op(ACT_LOAD, 1, 1, 1'b0, 24'h000000);
        pixel_op(ACT_UPDATE, 0, 0, 1'b0, 24'h000000);
        pixel_op(ACT_LOAD, 255, 255, 1'b1, 24'h000000);
        pixel_op(ACT_LOAD, 254, 255, 1'b0, 24'h000000);
        pixel_op(ACT_LOAD, 255, 254, 1'b1, 24'h000000);
        pixel_op(ACT_LOAD, 254, 254, 1'b1, 24'h000000);
        pixel_op(ACT_UPDATE, 255, 255, 1'b1, 24'h800000);
        pixel_op(ACT_UPDATE, 255, 255, 1'b0, 24'h7FFFFF);
        pixel_op(ACT_READ, 255, 255, 1'b0, 24'h000000);
        pixel_op(ACT_SPARE, 0, 0, 1'b1, 24'h000000);

        // single-pixel image: no neighbors, everything else outside
        apply_setting(-32768, 32767, 1, 1);
        pixel_op(ACT_LOAD, 0, 0, 1'b0, 24'h000000);
        pixel_op(ACT_UPDATE, 0, 0, 1'b1, 24'h000000);
        pixel_op(ACT_READ, 0, 1, 1'b0, 24'h000000);
        pixel_op(ACT_LOAD, 1, 0, 1'b1, 24'h000000);
        pixel_op(ACT_UPDATE, 255, 255, 1'b1, 24'h800000);

        // zero limits: every position outside
        apply_setting(0, 0, 0, 0);
        pixel_op(ACT_READ, 0, 0, 1'b0, 24'h000000);
        pixel_op(ACT_LOAD, 0, 0, 1'b1, 24'h000000);
        pixel_op(ACT_UPDATE, 0, 0, 1'b0, 24'h800000);

        // row limit above the store size clamps to it
        apply_setting(1024, -1024, 511, MAX_COLS);
        pixel_op(ACT_READ, 255, 255, 1'b0, 24'h000000);
        pixel_op(ACT_UPDATE, 255, 255, 1'b1, 24'h000000);

        phase = 0;
        while (items_sent < ITEM_TARGET)
        begin
            apply_setting(pick_weight(), pick_weight(), pick_limit(), pick_limit());
            if (phase == 1)
                pressure_req <= pressure_req + 1;
            calm <= (phase == 2);
            random_phase(PHASE_OPS);
            phase++;
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("%0d pixel transactions over %0d register settings, %0d updates, %0d flips",
                 items_sent, settings_used, update_count, flip_count);
        $display("%0d results checked, %0d outside the configured image",
                 checked_count, off_image_count);
        if (awaiting != 0)
            $display("%0t: %0d expected results never arrived", $time, awaiting);
        if (error_count == 0 && awaiting == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
